>>> src/srcomp_pkg.sv
// package for the sensor compensation core: payload types and shared constants
// no dependencies
`default_nettype none
package srcomp_pkg;

  typedef struct packed {
    logic [15:0] adc_hum;
    logic [19:0] adc_press;
    logic [19:0] adc_temp;
  } in_beat_t;

  typedef struct packed {
    logic [16:0]        hum_q10;
    logic [31:0]        press_pa;
    logic signed [31:0] temp_centi;
    logic signed [31:0] fine_temp;
  } out_beat_t;

  localparam logic [2:0] REG_TEMP    = 3'd0;
  localparam logic [2:0] REG_PRESS_A = 3'd1;
  localparam logic [2:0] REG_PRESS_B = 3'd2;
  localparam logic [2:0] REG_PRESS_C = 3'd3;
  localparam logic [2:0] REG_HUM_A   = 3'd4;
  localparam logic [2:0] REG_HUM_B   = 3'd5;

  localparam int DIV_W = 32;

  // divider stage word: one quotient bit resolved per stage
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] num;
    logic [31:0] den;
    logic [31:0] quo;
  } div_word_t;

  // one restoring division step
  function automatic div_word_t div_step(input div_word_t w);
    div_word_t   r;
    logic [32:0] trial;
    r = w;
    trial = {w.rem, w.num[31]};
    r.num = {w.num[30:0], 1'b0};
    if (trial >= {1'b0, w.den}) begin
      r.rem = 32'(trial - {1'b0, w.den});
      r.quo = {w.quo[30:0], 1'b1};
    end else begin
      r.rem = trial[31:0];
      r.quo = {w.quo[30:0], 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/sensor_raw_to_units_compensation_core.sv
// Raw-to-units compensation core. Every input beat (raw temperature, pressure
// and humidity) yields one output beat: fine temperature, temperature in
// 0.01 degC, pressure in Pa and humidity in Q7.10 percent, all with 32-bit
// wrapping integer arithmetic. The datapath is a single stall-driven pipeline
// that accepts a beat every cycle unless the output stalls; the 32-stage
// bit-per-stage pressure divider sits amid multiply stages. A stall on the
// output freezes the whole pipeline; one output register with a skid stage
// is not used, the pipeline itself advances when the last stage is empty or
// taken. Users must write coefficients on the cfg port while idle; unchecked.
// depends on srcomp_pkg and srcomp_div
`default_nettype none
module sensor_raw_to_units_compensation_core (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire srcomp_pkg::in_beat_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output srcomp_pkg::out_beat_t      out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [47:0]           cfg_data
);

  // coefficient registers
  logic [47:0] temp_coeffs, press_coeffs_a, press_coeffs_b, press_coeffs_c;
  logic [39:0] hum_coeffs_a;
  logic [31:0] hum_coeffs_b;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs    <= '0;
      press_coeffs_a <= '0;
      press_coeffs_b <= '0;
      press_coeffs_c <= '0;
      hum_coeffs_a   <= '0;
      hum_coeffs_b   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        srcomp_pkg::REG_TEMP:    temp_coeffs    <= cfg_data;
        srcomp_pkg::REG_PRESS_A: press_coeffs_a <= cfg_data;
        srcomp_pkg::REG_PRESS_B: press_coeffs_b <= cfg_data;
        srcomp_pkg::REG_PRESS_C: press_coeffs_c <= cfg_data;
        srcomp_pkg::REG_HUM_A:   hum_coeffs_a   <= cfg_data[39:0];
        srcomp_pkg::REG_HUM_B:   hum_coeffs_b   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // coefficient fields, sign or zero extended to 32 bits
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;
  assign t1 = {16'd0, temp_coeffs[15:0]};
  assign t2 = {{16{temp_coeffs[31]}}, temp_coeffs[31:16]};
  assign t3 = {{16{temp_coeffs[47]}}, temp_coeffs[47:32]};
  assign p1 = {16'd0, press_coeffs_a[15:0]};
  assign p2 = {{16{press_coeffs_a[31]}}, press_coeffs_a[31:16]};
  assign p3 = {{16{press_coeffs_a[47]}}, press_coeffs_a[47:32]};
  assign p4 = {{16{press_coeffs_b[15]}}, press_coeffs_b[15:0]};
  assign p5 = {{16{press_coeffs_b[31]}}, press_coeffs_b[31:16]};
  assign p6 = {{16{press_coeffs_b[47]}}, press_coeffs_b[47:32]};
  assign p7 = {{16{press_coeffs_c[15]}}, press_coeffs_c[15:0]};
  assign p8 = {{16{press_coeffs_c[31]}}, press_coeffs_c[31:16]};
  assign p9 = {{16{press_coeffs_c[47]}}, press_coeffs_c[47:32]};
  assign h1 = {24'd0, hum_coeffs_a[7:0]};
  assign h2 = {{16{hum_coeffs_a[23]}}, hum_coeffs_a[23:8]};
  assign h3 = {24'd0, hum_coeffs_a[31:24]};
  assign h6 = {{24{hum_coeffs_a[39]}}, hum_coeffs_a[39:32]};
  assign h4 = {{16{hum_coeffs_b[15]}}, hum_coeffs_b[15:0]};
  assign h5 = {{16{hum_coeffs_b[31]}}, hum_coeffs_b[31:16]};

  // whole pipeline advances together
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  function automatic logic [31:0] asr(input logic [31:0] x, input int n);
    return 32'($signed(x) >>> n);
  endfunction

  // ---------------- temperature, stages a..d ----------------
  logic        va, vb, vc, vd, ve, vf, vg, vh;
  logic [19:0] ap_a, ap_b, ap_c, ap_d, ap_e, ap_f;
  logic [15:0] ah_a, ah_b, ah_c, ah_d, ah_e;
  // stage a: first products
  logic [31:0] tm1_a, dd_a, at_d_a;
  always_ff @(posedge clk) begin
    if (en) begin
      tm1_a  <= 32'(({12'd0, in_data.adc_temp} >> 3) - (t1 << 1)) * t2;
      at_d_a <= ({12'd0, in_data.adc_temp} >> 4) - t1;
      ap_a   <= in_data.adc_press;
      ah_a   <= in_data.adc_hum;
    end
  end
  assign dd_a = at_d_a * at_d_a;
  // stage b
  logic [31:0] v1t_b, dsq_b;
  always_ff @(posedge clk) begin
    if (en) begin
      v1t_b <= asr(tm1_a, 11);
      dsq_b <= asr(dd_a, 12);
      ap_b  <= ap_a;
      ah_b  <= ah_a;
    end
  end
  // stage c: fine temperature
  logic [31:0] tfine_c;
  always_ff @(posedge clk) begin
    if (en) begin
      tfine_c <= v1t_b + asr(dsq_b * t3, 14);
      ap_c    <= ap_b;
      ah_c    <= ah_b;
    end
  end

  // ---------------- stage d: pressure/humidity first terms ----------------
  logic [31:0] tfine_d, tc5_d, pv1_d, pq_d, hx_d;
  always_ff @(posedge clk) begin
    if (en) begin
      tfine_d <= tfine_c;
      tc5_d   <= tfine_c * 32'd5 + 32'd128;
      pv1_d   <= asr(tfine_c, 1) - 32'd64000;
      pq_d    <= asr(asr(tfine_c, 1) - 32'd64000, 2);
      hx_d    <= tfine_c - 32'd76800;
      ap_d    <= ap_c;
      ah_d    <= ah_c;
    end
  end

  // stage e: squares and linear products
  logic [31:0] tfine_e, tc_e, qq_e, v1p5_e, v1p2_e;
  logic [31:0] hxh5_e, hxh6_e, hxh3_e;
  always_ff @(posedge clk) begin
    if (en) begin
      tfine_e <= tfine_d;
      tc_e    <= asr(tc5_d, 8);
      qq_e    <= pq_d * pq_d;
      v1p5_e  <= pv1_d * p5;
      v1p2_e  <= p2 * pv1_d;
      hxh5_e  <= h5 * hx_d;
      hxh6_e  <= asr(hx_d * h6, 10);
      hxh3_e  <= asr(hx_d * h3, 11) + 32'd32768;
      ap_e    <= ap_d;
      ah_e    <= ah_d;
    end
  end

  // stage f
  logic [31:0] tfine_f, tc_f, v2a_f, v1a_f, hA_f, hB_f;
  always_ff @(posedge clk) begin
    if (en) begin
      tfine_f <= tfine_e;
      tc_f    <= tc_e;
      v2a_f   <= asr(asr(qq_e, 11) * p6 + (v1p5_e << 1), 2) + (p4 << 16);
      v1a_f   <= asr(p3 * asr(qq_e, 13), 3) + asr(v1p2_e, 1);
      hA_f    <= asr(({16'd0, ah_e} << 14) - (h4 << 20) - hxh5_e + 32'd16384, 15);
      hB_f    <= hxh6_e * hxh3_e;
      ap_f    <= ap_e;
    end
  end

  // stage g: pressure divisor and numerator, humidity b term
  logic [31:0] tfine_g, tc_g, pden_g, pnum_g, hA_g, hB_g;
  always_ff @(posedge clk) begin
    if (en) begin
      tfine_g <= tfine_f;
      tc_g    <= tc_f;
      pden_g  <= asr((32'd32768 + asr(v1a_f, 18)) * p1, 15);
      pnum_g  <= ((32'd1048576 - {12'd0, ap_f}) - asr(v2a_f, 12)) * 32'd3125;
      hA_g    <= hA_f;
      hB_g    <= (asr(hB_f, 10) + 32'd2097152) * h2 + 32'd8192;
    end
  end

  // stage h: humidity product, divider operands
  logic [31:0] hx_h, div_num_h, pden_h;
  logic        big_h, zero_h;
  logic [31:0] tfine_h, tc_h;
  always_ff @(posedge clk) begin
    if (en) begin
      hx_h      <= hA_g * asr(hB_g, 14);
      big_h     <= pnum_g[31];
      zero_h    <= (pden_g == 32'd0);
      div_num_h <= pnum_g[31] ? pnum_g : (pnum_g << 1);
      pden_h    <= pden_g;
      tfine_h   <= tfine_g;
      tc_h      <= tc_g;
    end
  end

  // stage i: humidity correction product
  logic [31:0] hx_i, hsq_i;
  always_ff @(posedge clk) begin
    if (en) begin
      hx_i  <= hx_h;
      hsq_i <= asr(asr(hx_h, 15) * asr(hx_h, 15), 7);
    end
  end
  // stage j: humidity clamp
  logic [16:0] hum_j;
  logic [31:0] hfin;
  always_comb begin
    hfin = hx_i - asr(hsq_i * h1, 4);
    if (hfin[31]) hfin = 32'd0;
    if (hfin > 32'd419430400) hfin = 32'd419430400;
  end
  always_ff @(posedge clk) begin
    if (en) hum_j <= hfin[28:12];
  end

  // valid chain through the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      {va, vb, vc, vd, ve, vf, vg, vh} <= '0;
    end else if (en) begin
      {va, vb, vc, vd, ve, vf, vg, vh} <= {in_valid, va, vb, vc, vd, ve, vf, vg};
    end
  end

  // divider with side data: delay everything else by the divider depth
  logic        dv_out;
  logic [31:0] dq;
  logic [63:0] side_a_out;
  logic [31:0] den_safe;
  assign den_safe = zero_h ? 32'd1 : pden_h;

  logic [16:0] hum_x;
  assign hum_x = hum_j;

  srcomp_div u_div_a (
    .clk(clk), .rst(rst), .en(en), .in_valid(vh),
    .num(div_num_h), .den(den_safe),
    .side_in({tfine_h, tc_h}),
    .out_valid(dv_out), .quo(dq), .side_out(side_a_out)
  );

  // pressure flags ride beside the divider, one register per divider stage
  logic [1:0] flg_sr [srcomp_pkg::DIV_W];
  always_ff @(posedge clk) begin
    if (en) begin
      flg_sr[0] <= {zero_h, big_h};
      for (int i = 1; i < srcomp_pkg::DIV_W; i++) flg_sr[i] <= flg_sr[i-1];
    end
  end

  logic [16:0] hum_dly;
  always_ff @(posedge clk) begin
    if (en) hum_dly <= hum_x;
  end

  // humidity is two stages behind the divider input: delay it by 30 more registers
  logic [16:0] hum_sr [29];
  always_ff @(posedge clk) begin
    if (en) begin
      hum_sr[0] <= hum_dly;
      for (int i = 1; i < 29; i++) hum_sr[i] <= hum_sr[i-1];
    end
  end

  // stages p1 and p2: pressure quotient, then compensation products
  logic        vp1, vp2, vp3;
  logic [31:0] pr_p1, tfine_p1, tc_p1;
  logic        zero_p1;
  logic [16:0] hum_p1;
  always_ff @(posedge clk) begin
    if (en) begin
      pr_p1    <= flg_sr[srcomp_pkg::DIV_W-1][0] ? (dq << 1) : dq;
      zero_p1  <= flg_sr[srcomp_pkg::DIV_W-1][1];
      tfine_p1 <= side_a_out[63:32];
      tc_p1    <= side_a_out[31:0];
      hum_p1   <= hum_sr[28];
    end
  end
  logic [31:0] w1a_p2, w2_p2, pr_p2, tfine_p2, tc_p2;
  logic        zero_p2;
  logic [16:0] hum_p2;
  always_ff @(posedge clk) begin
    if (en) begin
      w1a_p2   <= (pr_p1 >> 3) * (pr_p1 >> 3);
      w2_p2    <= asr((pr_p1 >> 2) * p8, 13);
      pr_p2    <= pr_p1;
      zero_p2  <= zero_p1;
      tfine_p2 <= tfine_p1;
      tc_p2    <= tc_p1;
      hum_p2   <= hum_p1;
    end
  end
  srcomp_pkg::out_beat_t res_p3;
  always_ff @(posedge clk) begin
    if (en) begin
      res_p3.press_pa   <= zero_p2 ? 32'd0 :
        pr_p2 + asr(asr(p9 * (w1a_p2 >> 13), 12) + w2_p2 + p7, 4);
      res_p3.fine_temp  <= tfine_p2;
      res_p3.temp_centi <= tc_p2;
      res_p3.hum_q10    <= hum_p2;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      {vp1, vp2, vp3} <= '0;
    end else if (en) begin
      {vp1, vp2, vp3} <= {dv_out, vp1, vp2};
    end
  end

  assign out_valid = vp3;
  assign out_data  = res_p3;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall mismatch");
  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.hum_q10 <= 17'd102400)
    else $error("humidity out of range");
`endif

endmodule
`default_nettype wire

>>> src/srcomp_div.sv
// pipelined 32-bit unsigned divider, one quotient bit per stage, with stall
// depends on srcomp_pkg
`default_nettype none
module srcomp_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [31:0] num,
  input  wire logic [31:0] den,
  input  wire logic [63:0] side_in,
  output logic             out_valid,
  output logic [31:0]      quo,
  output logic [63:0]      side_out
);

  srcomp_pkg::div_word_t w    [srcomp_pkg::DIV_W+1];
  srcomp_pkg::div_word_t stg  [srcomp_pkg::DIV_W];
  logic [63:0]           side [srcomp_pkg::DIV_W];
  logic [srcomp_pkg::DIV_W-1:0] vld;

  assign w[0] = '{rem: 32'd0, num: num, den: den, quo: 32'd0};

  for (genvar i = 0; i < srcomp_pkg::DIV_W; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        stg[i]  <= srcomp_pkg::div_step(w[i]);
        side[i] <= (i == 0) ? side_in : side[(i == 0) ? 0 : i-1];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= (i == 0) ? in_valid : vld[(i == 0) ? 0 : i-1];
      end
    end
    assign w[i+1] = stg[i];
  end

  assign out_valid = vld[srcomp_pkg::DIV_W-1];
  assign quo       = w[srcomp_pkg::DIV_W].quo;
  assign side_out  = side[srcomp_pkg::DIV_W-1];

endmodule
`default_nettype wire
